[rtl/sspu_pkg.sv]
// shared types and constants of the sprite screen projection unit
`default_nettype none
package sspu_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_PLAYER_X      = 3'd0,
		CFG_PLAYER_Y      = 3'd1,
		CFG_DIR_X         = 3'd2,
		CFG_DIR_Y         = 3'd3,
		CFG_PLANE_X       = 3'd4,
		CFG_PLANE_Y       = 3'd5,
		CFG_SCREEN_WIDTH  = 3'd6,
		CFG_SCREEN_HEIGHT = 3'd7
	} cfg_idx_t;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned SCR_W     = 13;

	// camera setup as held in the configuration registers
	typedef struct packed {
		logic signed [WORD_W-1:0] player_x;
		logic signed [WORD_W-1:0] player_y;
		logic signed [WORD_W-1:0] dir_x;
		logic signed [WORD_W-1:0] dir_y;
		logic signed [WORD_W-1:0] plane_x;
		logic signed [WORD_W-1:0] plane_y;
		logic        [SCR_W-1:0]  screen_width;
		logic        [SCR_W-1:0]  screen_height;
	} cam_t;

	// transformed sprite handed from front to back
	typedef struct packed {
		logic signed [WORD_W-1:0] det;
		logic signed [WORD_W-1:0] nx;
		logic signed [WORD_W-1:0] ny;
	} proj_t;

endpackage
`default_nettype wire

[rtl/sprite_screen_projection_unit.sv]
// top level of the billboard sprite screen projection unit
//
// One sprite world position enters on the input channel (in_valid, in_ready,
// sprite_x, sprite_y); one projected result leaves on the output channel
// (out_valid, out_ready and the result fields). Camera and screen size sit in
// eight registers written through cfg_we, cfg_index and cfg_data; write them
// only while no item is in flight.
// One item is accepted per cycle while the receiver keeps up: both divider pairs
// are pipelined one quotient bit per stage, and the matrix products use six
// parallel multipliers.
// The front half (offset and products) feeds a four entry queue; the back half
// (divides and clamps) drains it. When the receiver stalls, the back half
// holds, the queue fills, and in_ready falls only once the front has also
// backed up. Reset empties the pipeline and queue and loads the default
// camera: player at the origin, facing +x, 640 by 480 screen.
`default_nettype none
module sprite_screen_projection_unit #(
	parameter int unsigned FRAC_BITS  = 16,
	parameter int unsigned MAX_SCREEN = 4096
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [sspu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sspu_pkg::WORD_W-1:0]        cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [31:0]                 sprite_x,
	input  wire logic signed [31:0]                 sprite_y,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [31:0]                      depth,
	output logic signed [15:0]                      centre_column,
	output logic        [15:0]                      sprite_size,
	output logic        [11:0]                      start_row,
	output logic        [11:0]                      end_row,
	output logic        [11:0]                      start_column,
	output logic        [11:0]                      end_column,
	output logic                                    behind
);

	sspu_pkg::cam_t cam_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q.player_x      <= 32'sd0;
			cam_q.player_y      <= 32'sd0;
			cam_q.dir_x         <= 32'sd65536;
			cam_q.dir_y         <= 32'sd0;
			cam_q.plane_x       <= 32'sd0;
			cam_q.plane_y       <= 32'sd43254;
			cam_q.screen_width  <= 13'd640;
			cam_q.screen_height <= 13'd480;
		end else if (cfg_we) begin
			case (sspu_pkg::cfg_idx_t'(cfg_index))
				sspu_pkg::CFG_PLAYER_X:      cam_q.player_x      <= cfg_data;
				sspu_pkg::CFG_PLAYER_Y:      cam_q.player_y      <= cfg_data;
				sspu_pkg::CFG_DIR_X:         cam_q.dir_x         <= cfg_data;
				sspu_pkg::CFG_DIR_Y:         cam_q.dir_y         <= cfg_data;
				sspu_pkg::CFG_PLANE_X:       cam_q.plane_x       <= cfg_data;
				sspu_pkg::CFG_PLANE_Y:       cam_q.plane_y       <= cfg_data;
				sspu_pkg::CFG_SCREEN_WIDTH:  cam_q.screen_width  <= cfg_data[12:0];
				sspu_pkg::CFG_SCREEN_HEIGHT: cam_q.screen_height <= cfg_data[12:0];
				default: begin
				end
			endcase
		end
	end

	logic            f_valid, f_ready, b_valid, b_ready;
	sspu_pkg::proj_t f_data, b_data;

	// front half
	sspu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cam       (cam_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sprite_x  (sprite_x),
		.sprite_y  (sprite_y),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_data  (f_data)
	);

	// queue between halves
	sspu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_data  (b_data)
	);

	// back half
	sspu_back #(.FRAC_BITS(FRAC_BITS), .MAX_SCREEN(MAX_SCREEN)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cam           (cam_q),
		.in_valid      (b_valid),
		.in_ready      (b_ready),
		.in_data       (b_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.depth         (depth),
		.centre_column (centre_column),
		.sprite_size   (sprite_size),
		.start_row     (start_row),
		.end_row       (end_row),
		.start_column  (start_column),
		.end_column    (end_column),
		.behind        (behind)
	);

endmodule
`default_nettype wire

[rtl/sspu_div.sv]
// pipelined restoring divider, one quotient bit per stage, unsigned magnitudes
`default_nettype none
module sspu_div #(
	parameter int unsigned NW = 48,
	parameter int unsigned DW = 32,
	parameter int unsigned SW = 1
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [SW-1:0] side_in,
	output logic      [NW-1:0] quo,
	output logic      [SW-1:0] side_out
);

	logic [DW-1:0] rem_q  [NW];
	logic [NW-1:0] acc_q  [NW];
	logic [DW-1:0] den_q  [NW];
	logic [SW-1:0] side_q [NW];

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [NW-1:0] acc_in;
		logic [SW-1:0] side_st;
		logic [DW:0]   trial;
		logic [DW:0]   diff;

		// stage inputs
		if (i == 0) begin : g_first
			assign rem_in  = '0;
			assign acc_in  = num;
			assign den_in  = den;
			assign side_st = side_in;
		end else begin : g_next
			assign rem_in  = rem_q[i-1];
			assign acc_in  = acc_q[i-1];
			assign den_in  = den_q[i-1];
			assign side_st = side_q[i-1];
		end

		// shift in next dividend bit and try a subtract
		assign trial = {rem_in, acc_in[NW-1]};
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				if (trial >= {1'b0, den_in}) begin
					rem_q[i] <= diff[DW-1:0];
					acc_q[i] <= {acc_in[NW-2:0], 1'b1};
				end else begin
					rem_q[i] <= trial[DW-1:0];
					acc_q[i] <= {acc_in[NW-2:0], 1'b0};
				end
				den_q[i]  <= den_in;
				side_q[i] <= side_st;
			end
		end
	end

	assign quo      = acc_q[NW-1];
	assign side_out = side_q[NW-1];

endmodule
`default_nettype wire

[rtl/sspu_front.sv]
// front end: accepts sprites, offsets them and applies the camera matrix products
`default_nettype none
module sspu_front #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sspu_pkg::cam_t       cam,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic signed [31:0]   sprite_x,
	input  wire logic signed [31:0]   sprite_y,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output sspu_pkg::proj_t           out_data
);

	localparam logic signed [64:0] S_MAX = 65'sd2147483647;
	localparam logic signed [64:0] S_MIN = -65'sd2147483648;

	logic v_s1, v_s2, v_s3;
	logic adv;

	logic signed [31:0] dx_s1, dy_s1;
	logic signed [63:0] p_det_a_s2, p_det_b_s2, p_nx_a_s2, p_nx_b_s2, p_ny_a_s2, p_ny_b_s2;
	sspu_pkg::proj_t    proj_s3;

	logic signed [32:0] dx_w, dy_w;

	// saturate a 33 bit difference to 32 bits
	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			sat33 = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			sat33 = v[31:0];
		end
	endfunction

	// floor shift of a product difference, then saturate
	function automatic logic signed [31:0] shift_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] d;
		logic signed [64:0] s;
		d = {a[63], a} - {b[63], b};
		s = d >>> FRAC_BITS;
		if (s > S_MAX) begin
			shift_sat = 32'sh7fff_ffff;
		end else if (s < S_MIN) begin
			shift_sat = 32'sh8000_0000;
		end else begin
			shift_sat = s[31:0];
		end
	endfunction

	assign adv      = !v_s3 || out_ready;
	assign in_ready = adv;

	assign dx_w = {sprite_x[31], sprite_x} - {cam.player_x[31], cam.player_x};
	assign dy_w = {sprite_y[31], sprite_y} - {cam.player_y[31], cam.player_y};

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// offset, products, shift and saturate
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= sat33(dx_w);
			dy_s1 <= sat33(dy_w);

			p_det_a_s2 <= $signed(cam.plane_x) * $signed(cam.dir_y);
			p_det_b_s2 <= $signed(cam.dir_x) * $signed(cam.plane_y);
			p_nx_a_s2  <= $signed(cam.dir_y) * dx_s1;
			p_nx_b_s2  <= $signed(cam.dir_x) * dy_s1;
			p_ny_a_s2  <= $signed(cam.plane_x) * dy_s1;
			p_ny_b_s2  <= $signed(cam.plane_y) * dx_s1;

			proj_s3.det <= shift_sat(p_det_a_s2, p_det_b_s2);
			proj_s3.nx  <= shift_sat(p_nx_a_s2, p_nx_b_s2);
			proj_s3.ny  <= shift_sat(p_ny_a_s2, p_ny_b_s2);
		end
	end

	assign out_valid = v_s3;
	assign out_data  = proj_s3;

endmodule
`default_nettype wire

[rtl/sspu_queue.sv]
// short item queue between the front and back halves
`default_nettype none
module sspu_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire sspu_pkg::proj_t in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output sspu_pkg::proj_t      out_data
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	sspu_pkg::proj_t mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            push, pop;

	assign in_ready  = cnt_q != CW'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

endmodule
`default_nettype wire

[rtl/sspu_back.sv]
// back end: divides by the determinant and depth, then clamps to the screen
`default_nettype none
module sspu_back #(
	parameter int unsigned FRAC_BITS  = 16,
	parameter int unsigned MAX_SCREEN = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sspu_pkg::cam_t     cam,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire sspu_pkg::proj_t    in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      depth,
	output logic signed [15:0]      centre_column,
	output logic        [15:0]      sprite_size,
	output logic        [11:0]      start_row,
	output logic        [11:0]      end_row,
	output logic        [11:0]      start_column,
	output logic        [11:0]      end_column,
	output logic                    behind
);

	localparam int unsigned WB  = $clog2(MAX_SCREEN + 1);
	localparam int unsigned CW  = (WB > sspu_pkg::SCR_W) ? WB : sspu_pkg::SCR_W;
	localparam int unsigned NW1 = 32 + FRAC_BITS;
	localparam int unsigned NW2 = WB + 33;
	localparam int unsigned PW  = WB + 34;
	localparam int unsigned EW  = NW2 + 3;
	localparam int unsigned TOT = NW1 + NW2 + 5;

	logic           adv, pop;
	logic [TOT-1:0] v_q;

	// effective screen size
	logic [CW-1:0] sw_c, sh_c;
	logic [WB-1:0] w_eff, h_eff;

	always_comb begin
		sw_c = CW'(cam.screen_width);
		sh_c = CW'(cam.screen_height);
		if (sw_c == '0) begin
			sw_c = CW'(1);
		end else if (sw_c > CW'(MAX_SCREEN)) begin
			sw_c = CW'(MAX_SCREEN);
		end
		if (sh_c == '0) begin
			sh_c = CW'(1);
		end else if (sh_c > CW'(MAX_SCREEN)) begin
			sh_c = CW'(MAX_SCREEN);
		end
		w_eff = sw_c[WB-1:0];
		h_eff = sh_c[WB-1:0];
	end

	assign adv      = !v_q[TOT-1] || out_ready;
	assign in_ready = adv;
	assign pop      = in_valid && adv;

	// valid chain through the whole back pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[TOT-2:0], pop};
		end
	end

	// magnitudes for the determinant divides
	logic [31:0] nx_u, ny_u, det_u, nx_mag, ny_mag, det_mag;
	assign nx_u    = in_data.nx;
	assign ny_u    = in_data.ny;
	assign det_u   = in_data.det;
	assign nx_mag  = nx_u[31] ? (~nx_u + 32'd1) : nx_u;
	assign ny_mag  = ny_u[31] ? (~ny_u + 32'd1) : ny_u;
	assign det_mag = det_u[31] ? (~det_u + 32'd1) : det_u;

	logic [NW1-1:0] q_tx, q_ty;
	logic [1:0]     side_tx;
	logic           side_ty;

	sspu_div #(.NW(NW1), .DW(32), .SW(2)) u_div_tx (
		.clk      (clk),
		.en       (adv),
		.num      ({nx_mag, {FRAC_BITS{1'b0}}}),
		.den      (det_mag),
		.side_in  ({nx_u[31] ^ det_u[31], det_u == 32'd0}),
		.quo      (q_tx),
		.side_out (side_tx)
	);

	sspu_div #(.NW(NW1), .DW(32), .SW(1)) u_div_ty (
		.clk      (clk),
		.en       (adv),
		.num      ({ny_mag, {FRAC_BITS{1'b0}}}),
		.den      (det_mag),
		.side_in  (ny_u[31] ^ det_u[31]),
		.quo      (q_ty),
		.side_out (side_ty)
	);

	// signed saturation of a quotient magnitude
	function automatic logic signed [31:0] sat_quo(input logic [NW1-1:0] q, input logic neg);
		if (!neg) begin
			sat_quo = (q > NW1'(32'h7fff_ffff)) ? 32'sh7fff_ffff : q[31:0];
		end else begin
			sat_quo = (q > NW1'(32'h8000_0000)) ? 32'sh8000_0000 : (~q[31:0] + 32'd1);
		end
	endfunction

	// clamp to zero and an upper bound, keep the low bits
	function automatic logic [11:0] clamp_lim(input logic signed [EW-1:0] v,
			input logic signed [EW-1:0] hi);
		if (v < 0) begin
			clamp_lim = 12'd0;
		end else if (v > hi) begin
			clamp_lim = hi[11:0];
		end else begin
			clamp_lim = v[11:0];
		end
	endfunction

	logic signed [31:0] tx_b1, ty_b1, ty_b2, ty_b3, ty_b5;
	logic               dz_b1, beh_b2, beh_b3, beh_b5;
	logic signed [32:0] sum_b2;
	logic signed [PW-1:0] prod_b3;
	logic signed [NW2:0]  cx_b5;
	logic [NW2-1:0]       size_b5;

	// saturate offsets, form the numerator sum and product
	always_ff @(posedge clk) begin
		if (adv) begin
			dz_b1 <= side_tx[0];
			tx_b1 <= side_tx[0] ? 32'sd0 : sat_quo(q_tx, side_tx[1]);
			ty_b1 <= side_tx[0] ? 32'sd0 : sat_quo(q_ty, side_ty);

			sum_b2 <= {ty_b1[31], ty_b1} + {tx_b1[31], tx_b1};
			beh_b2 <= dz_b1 || (ty_b1 <= 32'sd0);
			ty_b2  <= ty_b1;

			prod_b3 <= $signed({1'b0, w_eff >> 1}) * sum_b2;
			beh_b3  <= beh_b2;
			ty_b3   <= ty_b2;
		end
	end

	// inputs to the depth divides
	logic [PW-1:0]  prod_u, prod_mag;
	logic [NW2-1:0] q_cx, q_size;
	logic [1:0]     side_cx;
	logic [31:0]    side_size;

	assign prod_u   = prod_b3;
	assign prod_mag = prod_u[PW-1] ? (~prod_u + PW'(1)) : prod_u;

	sspu_div #(.NW(NW2), .DW(32), .SW(2)) u_div_cx (
		.clk      (clk),
		.en       (adv),
		.num      (prod_mag[NW2-1:0]),
		.den      (ty_b3),
		.side_in  ({prod_u[PW-1], beh_b3}),
		.quo      (q_cx),
		.side_out (side_cx)
	);

	sspu_div #(.NW(NW2), .DW(32), .SW(32)) u_div_size (
		.clk      (clk),
		.en       (adv),
		.num      (NW2'({h_eff, {FRAC_BITS{1'b0}}})),
		.den      (ty_b3),
		.side_in  (ty_b3),
		.quo      (q_size),
		.side_out (side_size)
	);

	// signed centre column and size
	always_ff @(posedge clk) begin
		if (adv) begin
			cx_b5   <= side_cx[1] ? -$signed({1'b0, q_cx}) : $signed({1'b0, q_cx});
			size_b5 <= q_size;
			beh_b5  <= side_cx[0];
			ty_b5   <= side_size;
		end
	end

	// screen clamps and output register
	logic signed [EW-1:0] hs_e, cx_e, hh_e, hmax_e, wmax_e;
	assign hs_e   = $signed({4'b0000, size_b5[NW2-1:1]});
	assign cx_e   = {{2{cx_b5[NW2]}}, cx_b5};
	assign hh_e   = $signed(EW'(h_eff >> 1));
	assign hmax_e = $signed(EW'(h_eff - WB'(1)));
	assign wmax_e = $signed(EW'(w_eff - WB'(1)));

	always_ff @(posedge clk) begin
		if (adv) begin
			depth  <= ty_b5;
			behind <= beh_b5;
			if (beh_b5) begin
				centre_column <= 16'sd0;
				sprite_size   <= 16'd0;
				start_row     <= 12'd0;
				end_row       <= 12'd0;
				start_column  <= 12'd0;
				end_column    <= 12'd0;
			end else begin
				if (cx_b5 > (NW2+1)'(32767)) begin
					centre_column <= 16'sh7fff;
				end else if (cx_b5 < (NW2+1)'(-32768)) begin
					centre_column <= 16'sh8000;
				end else begin
					centre_column <= cx_b5[15:0];
				end
				sprite_size  <= (size_b5 > NW2'(65535)) ? 16'hffff : size_b5[15:0];
				start_row    <= clamp_lim(hh_e - hs_e, hmax_e);
				end_row      <= clamp_lim(hh_e + hs_e, hmax_e);
				start_column <= clamp_lim(cx_e - hs_e, wmax_e);
				end_column   <= clamp_lim(cx_e + hs_e, wmax_e);
			end
		end
	end

	assign out_valid = v_q[TOT-1];

endmodule
`default_nettype wire
